// ===== hw/rtl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Types and constants shared by the instruction execute unit and its testbench.
// ----------------------------------------------------------------------------
package mse_pkg;

   localparam int DATA_BITS = 32;
   localparam int REG_BITS  = 5;
   localparam int REG_COUNT = 1 << REG_BITS;
   localparam int PC_BITS   = 26;
   localparam int PE_BITS   = 13;
   localparam int OP_BITS   = 5;
   localparam int IMM_BITS  = 16;
   localparam int ST_BITS   = 2;

   localparam logic [OP_BITS-1:0] OP_ADD  = 5'd1;
   localparam logic [OP_BITS-1:0] OP_SUB  = 5'd2;
   localparam logic [OP_BITS-1:0] OP_MUL  = 5'd3;
   localparam logic [OP_BITS-1:0] OP_SLT  = 5'd4;
   localparam logic [OP_BITS-1:0] OP_BNE  = 5'd5;
   localparam logic [OP_BITS-1:0] OP_BEQ  = 5'd6;
   localparam logic [OP_BITS-1:0] OP_J    = 5'd7;
   localparam logic [OP_BITS-1:0] OP_LW   = 5'd8;
   localparam logic [OP_BITS-1:0] OP_SW   = 5'd9;
   localparam logic [OP_BITS-1:0] OP_ADDI = 5'd10;

   localparam logic [ST_BITS-1:0] ST_OK     = 2'd0;
   localparam logic [ST_BITS-1:0] ST_FAULT  = 2'd1;
   localparam logic [ST_BITS-1:0] ST_BAD_OP = 2'd2;

   typedef struct packed {
      logic [PC_BITS-1:0]   next_pc;
      logic [ST_BITS-1:0]   status;
      logic                 reg_write;
      logic [REG_BITS-1:0]  reg_index;
      logic [DATA_BITS-1:0] reg_value;
   } result_type;

endpackage

// ===== hw/rtl/mse_ram.sv =====
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mips_subset_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Executes one encoded instruction per beat against a 32-entry register file
// and a word data memory, and returns the next pc, a status and the register
// write it made.
// ----------------------------------------------------------------------------
// Usage: req_ carries an instruction word and its pc, rsp_ returns one beat
// per instruction in order, csr_ writes program_end; the user must do so only
// while the unit is idle, the unit itself does not enforce it. A beat moves
// when valid is high and stall is low. A request passes stages 1, 2 and 3;
// the result is then pushed into a two-entry output queue and leaves on rsp_.
// Issue: req_stall is high while an instruction is in stage 1, so the next is
// taken only after it has left stage 1. The data memory read port is used
// twice per instruction (word and word+1), as is its write port for an
// unaligned store. An instruction whose rs or rd is the target of a load
// directly ahead of it waits while the load is in stage 2, for the load data.
// Reset: a clearing pass writes zero to every data memory word and register;
// req_stall is high during it. program_end resets to zero. While rsp_stall
// holds, req_stall rises at two outstanding instructions, falls on a pop.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit #(
   parameter int MEM_ADDR_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mse_pkg::DATA_BITS-1:0]        req_instruction_word,
   input  logic [mse_pkg::PC_BITS-1:0]          req_program_counter,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mse_pkg::PC_BITS-1:0]          rsp_next_pc,
   output logic [mse_pkg::ST_BITS-1:0]          rsp_status,
   output logic                                 rsp_reg_write,
   output logic [mse_pkg::REG_BITS-1:0]         rsp_reg_index,
   output logic signed [mse_pkg::DATA_BITS-1:0] rsp_reg_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mse_pkg::PE_BITS-1:0]          csr_program_end
);

   localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;
   localparam int AW = 34;
   localparam logic signed [AW-1:0] DEPTH_S = AW'(MEM_DEPTH);
   localparam int DW = mse_pkg::DATA_BITS;
   localparam int RW = mse_pkg::REG_BITS;
   localparam int PW = mse_pkg::PC_BITS;
   localparam int OW = mse_pkg::OP_BITS;
   localparam int SW = mse_pkg::ST_BITS;
   localparam int IW = mse_pkg::IMM_BITS;

   // configuration and clearing pass
   logic [mse_pkg::PE_BITS-1:0] program_end_ff;
   logic                        clr_active_ff, clr_active_in;
   logic [MEM_ADDR_BITS-1:0]    clr_cnt_ff, clr_cnt_in;

   // pipeline control
   logic       v1_ff, v2_ff, v3_ff;
   logic [1:0] occ_ff, occ_in;
   logic       req_accept, hazard, room;

   // stage 1
   logic [DW-1:0] iw1_ff;
   logic [PW-1:0] pc1_ff;
   logic [OW-1:0] op1;
   logic [IW-1:0] imm1;
   logic [DW-1:0] a1, b1;
   logic signed [AW-1:0] word1;
   logic          fault1, mem_ok1;
   logic [PW-1:0] npc1;
   logic [SW-1:0] status1;

   // stage 2
   logic [OW-1:0]            op2_ff;
   logic [RW-1:0]            rd2_ff;
   logic [IW-1:0]            imm2_ff;
   logic [MEM_ADDR_BITS-1:0] loc2_ff;
   logic                     mem_ok2_ff;
   logic [DW-1:0]            a2_ff, b2_ff;
   logic [PW-1:0]            npc2_ff;
   logic [SW-1:0]            status2_ff;
   logic [DW-1:0]            c2, m0, alu_val, st_data0, low2;
   logic                     alu_wr, alu_wr_en, st_wr, load2;
   logic [5:0]               s2;

   // stage 3
   logic [RW-1:0]            rd3_ff;
   logic                     wr3_ff, load3_ff, split3_ff;
   logic [1:0]               rem3_ff;
   logic [MEM_ADDR_BITS-1:0] loc3_ff;
   logic [DW-1:0]            a3_ff, m0_3_ff, val3_ff;
   logic [PW-1:0]            npc3_ff;
   logic [SW-1:0]            status3_ff;
   logic [DW-1:0]            m1, ld_val, st_data1, low3;
   logic [5:0]               s3;

   // register file banks
   logic [RW-1:0] rf0_raddr, rf1_raddr, rf0_raddr_ff, rf1_raddr_ff;
   logic [DW-1:0] rf0_q, rf1_q, rf0_data, rf1_data;
   logic          rf_wr_en;
   logic [RW-1:0] rf_wr_addr;
   logic [DW-1:0] rf_wr_data;
   logic          rf_byp_v_ff;
   logic [RW-1:0] rf_byp_idx_ff;
   logic [DW-1:0] rf_byp_val_ff;

   // data memory
   logic [MEM_ADDR_BITS-1:0] mem_raddr, mem_raddr_ff, mem_wr_addr, mem_byp_addr_ff;
   logic [DW-1:0]            mem_q, mem_data, mem_wr_data, mem_byp_val_ff;
   logic                     mem_wr_en, mem_byp_v_ff;

   // output queue
   mse_pkg::result_type rq_ff [2];
   mse_pkg::result_type push_res;
   logic       q_wr_ptr_ff, q_rd_ptr_ff, rsp_pop;
   logic [1:0] q_count_ff;

   // ---------------------------------------------------------------- control
   assign csr_ready = 1'b1;
   assign rsp_pop   = rsp_valid && !rsp_stall;
   assign hazard    = v2_ff && (op2_ff == mse_pkg::OP_LW) &&
                      ((req_instruction_word[20:16] == rd2_ff) ||
                       (req_instruction_word[25:21] == rd2_ff));
   assign room       = (occ_ff < 2'd2) || rsp_pop;
   assign req_stall  = clr_active_ff || v1_ff || hazard || !room;
   assign req_accept = req_valid && !req_stall;
   assign occ_in     = occ_ff + {1'b0, req_accept} - {1'b0, rsp_pop};
   assign clr_cnt_in    = clr_cnt_ff + MEM_ADDR_BITS'(1);
   assign clr_active_in = clr_active_ff && (clr_cnt_ff != '1);

   // ---------------------------------------------------------------- reads
   assign rf0_raddr = v1_ff ? iw1_ff[15:11] : req_instruction_word[20:16];
   assign rf1_raddr = req_instruction_word[25:21];
   assign rf0_data  = (rf_byp_v_ff && rf_byp_idx_ff == rf0_raddr_ff) ? rf_byp_val_ff : rf0_q;
   assign rf1_data  = (rf_byp_v_ff && rf_byp_idx_ff == rf1_raddr_ff) ? rf_byp_val_ff : rf1_q;
   assign mem_raddr = v2_ff ? loc2_ff + MEM_ADDR_BITS'(1) : word1[MEM_ADDR_BITS-1:0];
   assign mem_data  = (mem_byp_v_ff && mem_byp_addr_ff == mem_raddr_ff) ?
                      mem_byp_val_ff : mem_q;

   // ---------------------------------------------------------------- stage 1
   assign op1   = iw1_ff[30:26];
   assign imm1  = iw1_ff[15:0];
   assign b1    = rf0_data;
   assign a1    = rf1_data;
   assign word1 = $signed({{2{b1[DW-1]}}, b1}) + $signed({20'd0, imm1[15:2]});
   assign fault1 = (word1 >= DEPTH_S) ||
                   ((word1 == DEPTH_S - AW'(1)) && (imm1[1:0] != 2'd0)) ||
                   (word1 <= $signed({21'd0, program_end_ff}));

   always_comb begin
      npc1    = pc1_ff + PW'(1);
      status1 = mse_pkg::ST_OK;
      mem_ok1 = 1'b0;
      case (op1)
         mse_pkg::OP_ADD, mse_pkg::OP_SUB, mse_pkg::OP_MUL,
         mse_pkg::OP_SLT, mse_pkg::OP_ADDI: begin
         end
         mse_pkg::OP_BNE: begin
            if (a1 != b1) begin
               npc1 = {10'd0, imm1};
            end
         end
         mse_pkg::OP_BEQ: begin
            if (a1 == b1) begin
               npc1 = {10'd0, imm1};
            end
         end
         mse_pkg::OP_J: begin
            npc1 = iw1_ff[PW-1:0];
         end
         mse_pkg::OP_LW, mse_pkg::OP_SW: begin
            if (fault1) begin
               npc1    = pc1_ff;
               status1 = mse_pkg::ST_FAULT;
            end else begin
               mem_ok1 = 1'b1;
            end
         end
         default: begin
            npc1    = pc1_ff;
            status1 = mse_pkg::ST_BAD_OP;
         end
      endcase
   end

   // ---------------------------------------------------------------- stage 2
   assign c2 = rf0_data;
   assign m0 = mem_data;

   always_comb begin
      alu_wr  = 1'b1;
      alu_val = '0;
      case (op2_ff)
         mse_pkg::OP_ADD:  alu_val = b2_ff + c2;
         mse_pkg::OP_SUB:  alu_val = b2_ff - c2;
         mse_pkg::OP_MUL:  alu_val = b2_ff * c2;
         mse_pkg::OP_SLT:  alu_val = {31'd0, $signed(b2_ff) < $signed(c2)};
         mse_pkg::OP_ADDI: alu_val = b2_ff + {16'd0, imm2_ff};
         default:          alu_wr  = 1'b0;
      endcase
   end

   assign alu_wr_en = v2_ff && alu_wr;
   assign load2     = (op2_ff == mse_pkg::OP_LW) && mem_ok2_ff;
   assign st_wr     = v2_ff && (op2_ff == mse_pkg::OP_SW) && mem_ok2_ff;
   assign s2        = {1'b0, imm2_ff[1:0], 3'b000};
   assign low2      = {DW{1'b1}} >> s2;
   assign st_data0  = (imm2_ff[1:0] == 2'd0) ? a2_ff : ((m0 & ~low2) | (a2_ff >> s2));

   // ---------------------------------------------------------------- stage 3
   assign m1       = mem_data;
   assign s3       = {1'b0, rem3_ff, 3'b000};
   assign low3     = {DW{1'b1}} >> s3;
   assign ld_val   = (rem3_ff == 2'd0) ? m0_3_ff : ((m0_3_ff << s3) | (m1 >> (6'd32 - s3)));
   assign st_data1 = (a3_ff << (6'd32 - s3)) | (m1 & low3);

   always_comb begin
      push_res.next_pc   = npc3_ff;
      push_res.status    = status3_ff;
      push_res.reg_write = wr3_ff;
      push_res.reg_index = wr3_ff ? rd3_ff : '0;
      push_res.reg_value = wr3_ff ? (load3_ff ? ld_val : val3_ff) : '0;
   end

   // ---------------------------------------------------------------- write ports
   always_comb begin
      rf_wr_en   = 1'b0;
      rf_wr_addr = '0;
      rf_wr_data = '0;
      if (clr_active_ff) begin
         rf_wr_en   = clr_cnt_ff < MEM_ADDR_BITS'(mse_pkg::REG_COUNT);
         rf_wr_addr = clr_cnt_ff[RW-1:0];
      end else if (v3_ff && load3_ff) begin
         rf_wr_en   = 1'b1;
         rf_wr_addr = rd3_ff;
         rf_wr_data = ld_val;
      end else if (alu_wr_en) begin
         rf_wr_en   = 1'b1;
         rf_wr_addr = rd2_ff;
         rf_wr_data = alu_val;
      end
   end

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      if (clr_active_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_cnt_ff;
      end else if (v3_ff && split3_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = loc3_ff;
         mem_wr_data = st_data1;
      end else if (st_wr) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = loc2_ff;
         mem_wr_data = st_data0;
      end
   end

   // ---------------------------------------------------------------- memories
   mse_ram #(.WIDTH(DW), .DEPTH(mse_pkg::REG_COUNT)) u_rf0 (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_addr),
      .wr_data (rf_wr_data),
      .rd_addr (rf0_raddr),
      .rd_data (rf0_q)
   );

   mse_ram #(.WIDTH(DW), .DEPTH(mse_pkg::REG_COUNT)) u_rf1 (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_addr),
      .wr_data (rf_wr_data),
      .rd_addr (rf1_raddr),
      .rd_data (rf1_q)
   );

   mse_ram #(.WIDTH(DW), .DEPTH(MEM_DEPTH)) u_dmem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         program_end_ff <= '0;
         clr_active_ff  <= 1'b1;
         clr_cnt_ff     <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         occ_ff         <= '0;
         rf_byp_v_ff    <= 1'b0;
         mem_byp_v_ff   <= 1'b0;
         q_count_ff     <= '0;
         q_wr_ptr_ff    <= 1'b0;
         q_rd_ptr_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            program_end_ff <= csr_program_end;
         end
         clr_active_ff <= clr_active_in;
         if (clr_active_ff) begin
            clr_cnt_ff <= clr_cnt_in;
         end
         v1_ff        <= req_accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         occ_ff       <= occ_in;
         rf_byp_v_ff  <= rf_wr_en;
         mem_byp_v_ff <= mem_wr_en;
         if (v3_ff) begin
            q_wr_ptr_ff <= !q_wr_ptr_ff;
         end
         if (rsp_pop) begin
            q_rd_ptr_ff <= !q_rd_ptr_ff;
         end
         q_count_ff <= q_count_ff + {1'b0, v3_ff} - {1'b0, rsp_pop};
      end
   end

   always_ff @(posedge clock) begin
      rf0_raddr_ff    <= rf0_raddr;
      rf1_raddr_ff    <= rf1_raddr;
      rf_byp_idx_ff   <= rf_wr_addr;
      rf_byp_val_ff   <= rf_wr_data;
      mem_raddr_ff    <= mem_raddr;
      mem_byp_addr_ff <= mem_wr_addr;
      mem_byp_val_ff  <= mem_wr_data;
      if (req_accept) begin
         iw1_ff <= req_instruction_word;
         pc1_ff <= req_program_counter;
      end
      if (v1_ff) begin
         op2_ff     <= op1;
         rd2_ff     <= iw1_ff[25:21];
         imm2_ff    <= imm1;
         loc2_ff    <= word1[MEM_ADDR_BITS-1:0];
         mem_ok2_ff <= mem_ok1;
         a2_ff      <= a1;
         b2_ff      <= b1;
         npc2_ff    <= npc1;
         status2_ff <= status1;
      end
      if (v2_ff) begin
         rd3_ff     <= rd2_ff;
         wr3_ff     <= alu_wr || load2;
         load3_ff   <= load2;
         split3_ff  <= st_wr && (imm2_ff[1:0] != 2'd0);
         rem3_ff    <= imm2_ff[1:0];
         loc3_ff    <= loc2_ff + MEM_ADDR_BITS'(1);
         a3_ff      <= a2_ff;
         m0_3_ff    <= m0;
         val3_ff    <= alu_val;
         npc3_ff    <= npc2_ff;
         status3_ff <= status2_ff;
      end
      if (v3_ff) begin
         rq_ff[q_wr_ptr_ff] <= push_res;
      end
   end

   // ---------------------------------------------------------------- response
   assign rsp_valid     = q_count_ff != 2'd0;
   assign rsp_next_pc   = rq_ff[q_rd_ptr_ff].next_pc;
   assign rsp_status    = rq_ff[q_rd_ptr_ff].status;
   assign rsp_reg_write = rq_ff[q_rd_ptr_ff].reg_write;
   assign rsp_reg_index = rq_ff[q_rd_ptr_ff].reg_index;
   assign rsp_reg_value = $signed(rq_ff[q_rd_ptr_ff].reg_value);

   // ---------------------------------------------------------------- assertions
   a_no_stage_overlap: assert property (@(posedge clock) disable iff (reset)
      !(v1_ff && v2_ff))
      else $error("two instructions in the address stage window");

   a_one_rf_write: assert property (@(posedge clock) disable iff (reset)
      !(v3_ff && load3_ff && alu_wr_en))
      else $error("load and alu register writes collide");

   a_one_mem_write: assert property (@(posedge clock) disable iff (reset)
      !(v3_ff && split3_ff && st_wr))
      else $error("two store writes in one cycle");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ((q_count_ff < 2'd2) || rsp_pop))
      else $error("result pushed into a full queue");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (occ_ff != 2'd3))
      else $error("more instructions outstanding than result slots");

endmodule

// ===== tb/tb_mips_subset_execute_unit.sv =====
// ----------------------------------------------------------------------------
// tb_mips_subset_execute_unit
// Drives encoded instructions into the execute unit and checks every result
// beat against an in-bench model of the register file and data memory. A
// short directed table covers the opcodes, fault cases and field extremes;
// random programs follow under several program_end settings and idle
// patterns on both channels.
// ----------------------------------------------------------------------------
module tb_mips_subset_execute_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import mse_pkg::*;

   localparam int MEM_ADDR_BITS = 12;
   localparam int MEM_WORDS     = 1 << MEM_ADDR_BITS;
   localparam int MAX_OFFSET    = (1 << (IMM_BITS - 2)) - 1;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [OP_BITS-1:0] OP_NONE = 5'd0;
   localparam result_type NO_RESULT = '0;

   typedef struct {
      logic [DATA_BITS-1:0] word;
      logic [PC_BITS-1:0]   pc;
      bit                   typed;
      result_type           res;
   } vector_row;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [DATA_BITS-1:0]        req_instruction_word = '0;
   logic [PC_BITS-1:0]          req_program_counter = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [PC_BITS-1:0]          rsp_next_pc;
   logic [ST_BITS-1:0]          rsp_status;
   logic                        rsp_reg_write;
   logic [REG_BITS-1:0]         rsp_reg_index;
   logic signed [DATA_BITS-1:0] rsp_reg_value;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [PE_BITS-1:0]          csr_program_end = '0;

   logic [DATA_BITS-1:0] reg_file_m [REG_COUNT];
   logic [DATA_BITS-1:0] data_mem_m [MEM_WORDS];
   logic [PE_BITS-1:0]   program_end_m;

   result_type expected_results [$];
   int outstanding = 0;
   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int n_items = 0;
   int n_faults = 0;
   int n_bad_ops = 0;
   int n_mem_ok = 0;

   mips_subset_execute_unit #(
      .MEM_ADDR_BITS(MEM_ADDR_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_instruction_word(req_instruction_word),
      .req_program_counter(req_program_counter),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_next_pc(rsp_next_pc),
      .rsp_status(rsp_status),
      .rsp_reg_write(rsp_reg_write),
      .rsp_reg_index(rsp_reg_index),
      .rsp_reg_value(rsp_reg_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_program_end(csr_program_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [DATA_BITS-1:0] encode(logic top, logic [OP_BITS-1:0] op,
         logic [REG_BITS-1:0] rd, logic [REG_BITS-1:0] rs, logic [IMM_BITS-1:0] low);
      return {top, op, rd, rs, low};
   endfunction

   function automatic vector_row row(logic [DATA_BITS-1:0] word, logic [PC_BITS-1:0] pc,
         bit typed, result_type res);
      vector_row v;
      v.word = word;
      v.pc = pc;
      v.typed = typed;
      v.res = res;
      return v;
   endfunction

   function automatic result_type execute_instruction(logic [DATA_BITS-1:0] iw,
         logic [PC_BITS-1:0] pc);
      logic [OP_BITS-1:0]   op;
      logic [REG_BITS-1:0]  rd, rs, rt;
      logic [IMM_BITS-1:0]  imm;
      logic [DATA_BITS-1:0] a, b, c, val, keep;
      logic [PC_BITS-1:0]   npc;
      logic [ST_BITS-1:0]   status;
      logic                 wr;
      longint               word;
      int                   sh;
      result_type           res;
      op = iw[30:26];
      rd = iw[25:21];
      rs = iw[20:16];
      rt = iw[15:11];
      imm = iw[15:0];
      a = reg_file_m[rd];
      b = reg_file_m[rs];
      c = reg_file_m[rt];
      npc = pc + 1'b1;
      status = ST_OK;
      wr = 1'b0;
      val = '0;
      case (op)
         OP_ADD: begin
            wr = 1'b1;
            val = b + c;
         end
         OP_SUB: begin
            wr = 1'b1;
            val = b - c;
         end
         OP_MUL: begin
            wr = 1'b1;
            val = b * c;
         end
         OP_SLT: begin
            wr = 1'b1;
            val = ($signed(b) < $signed(c)) ? 32'd1 : 32'd0;
         end
         OP_BNE: if (a != b) npc = PC_BITS'(imm);
         OP_BEQ: if (a == b) npc = PC_BITS'(imm);
         OP_J: npc = iw[PC_BITS-1:0];
         OP_ADDI: begin
            wr = 1'b1;
            val = b + DATA_BITS'(imm);
         end
         OP_LW, OP_SW: begin
            word = longint'($signed(b)) + longint'(imm >> 2);
            sh = 8 * int'(imm[1:0]);
            if (word >= MEM_WORDS || (word == MEM_WORDS - 1 && sh != 0) ||
                  word <= longint'(program_end_m)) begin
               status = ST_FAULT;
               npc = pc;
               n_faults++;
            end else begin
               n_mem_ok++;
               if (op == OP_LW) begin
                  wr = 1'b1;
                  if (sh == 0) val = data_mem_m[word];
                  else val = (data_mem_m[word] << sh) | (data_mem_m[word + 1] >> (32 - sh));
               end else if (sh == 0) begin
                  data_mem_m[word] = a;
               end else begin
                  // shifted logically so sign bits never leak into neighbor bytes
                  keep = 32'hFFFF_FFFF >> sh;
                  data_mem_m[word] = (data_mem_m[word] & ~keep) | (a >> sh);
                  data_mem_m[word + 1] = (a << (32 - sh)) | (data_mem_m[word + 1] & keep);
               end
            end
         end
         default: begin
            status = ST_BAD_OP;
            npc = pc;
            n_bad_ops++;
         end
      endcase
      if (wr) reg_file_m[rd] = val;
      res.next_pc = npc;
      res.status = status;
      res.reg_write = wr;
      res.reg_index = wr ? rd : '0;
      res.reg_value = wr ? val : '0;
      return res;
   endfunction

   task automatic issue(logic [DATA_BITS-1:0] iw, logic [PC_BITS-1:0] pc, bit typed,
         result_type typed_res);
      result_type want;
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instruction_word <= iw;
      req_program_counter <= pc;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = execute_instruction(iw, pc);
      expected_results.push_back(typed ? typed_res : want);
      outstanding++;
      n_items++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_program_end(logic [PE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_program_end <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      program_end_m = value;
   endtask

   task automatic make_random(output logic [DATA_BITS-1:0] iw, output logic [PC_BITS-1:0] pc);
      int                  pick, base, lo, wlo, whi, word;
      int                  bases [$];
      logic                top;
      logic [OP_BITS-1:0]  op;
      logic [REG_BITS-1:0] rd, rs, rt;
      logic [1:0]          rem;
      top = $urandom_range(0, 1);
      rd = $urandom_range(0, REG_COUNT - 1);
      rs = $urandom_range(0, REG_COUNT - 1);
      rt = $urandom_range(0, REG_COUNT - 1);
      rem = $urandom_range(0, 3);
      pc = ($urandom_range(0, 15) == 0) ? {PC_BITS{1'b1}} : PC_BITS'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         iw = $urandom();
      end else if (pick < 18) begin
         iw = encode(top, OP_SUB, rd, rs, {rs, 11'($urandom())});
      end else if (pick < 28) begin
         iw = encode(top, OP_ADDI, rd, rs, 16'($urandom()));
      end else if (pick < 38) begin
         case ($urandom_range(0, 2))
            0: op = OP_ADD;
            1: op = OP_SUB;
            default: op = OP_MUL;
         endcase
         iw = encode(top, op, rd, rs, {rt, 11'($urandom())});
      end else if (pick < 44) begin
         iw = encode(top, OP_SLT, rd, rs, {rt, 11'($urandom())});
      end else if (pick < 54) begin
         op = $urandom_range(0, 1) ? OP_BNE : OP_BEQ;
         if ($urandom_range(0, 2) == 0) rs = rd;
         iw = encode(top, op, rd, rs, 16'($urandom()));
      end else if (pick < 58) begin
         iw = {top, OP_J, 26'($urandom())};
      end else if (pick < 61) begin
         do op = $urandom(); while (op >= OP_ADD && op <= OP_ADDI);
         iw = {top, op, 26'($urandom())};
      end else begin
         op = $urandom_range(0, 1) ? OP_LW : OP_SW;
         lo = int'(program_end_m) + 1;
         for (int r = 0; r < REG_COUNT; r++) begin
            base = $signed(reg_file_m[r]);
            if (base < MEM_WORDS && base >= lo - MAX_OFFSET) bases.push_back(r);
         end
         if (lo >= MEM_WORDS) begin
            iw = encode(top, op, rd, rs, 16'($urandom()));
         end else if (bases.size() == 0) begin
            // no usable base register left, clear one
            iw = encode(top, OP_SUB, rd, rs, {rs, 11'($urandom())});
         end else begin
            rs = bases[$urandom_range(0, bases.size() - 1)];
            base = $signed(reg_file_m[rs]);
            wlo = (base > lo) ? base : lo;
            whi = (base + MAX_OFFSET < MEM_WORDS) ? base + MAX_OFFSET : MEM_WORDS - 1;
            pick = $urandom_range(0, 99);
            if (pick < 70 && wlo <= lo + 15) word = $urandom_range(wlo, (whi < lo + 15) ? whi : lo + 15);
            else if (pick < 85) word = $urandom_range(wlo, whi);
            else if (pick < 93) word = whi;
            else word = (lo - 1 >= base) ? lo - 1 : wlo;
            iw = encode(top, op, rd, rs, {14'(word - base), rem});
         end
      end
   endtask

   task automatic run_segment(int sender_pct, int receiver_pct, logic [PE_BITS-1:0] pe,
         int count);
      logic [DATA_BITS-1:0] iw;
      logic [PC_BITS-1:0]   pc;
      drain();
      send_idle = sender_pct;
      recv_idle = receiver_pct;
      set_program_end(pe);
      for (int k = 0; k < count; k++) begin
         // hold off until the unit is empty once per segment
         if (k == count / 2) drain();
         make_random(iw, pc);
         issue(iw, pc, 1'b0, NO_RESULT);
      end
   endtask

   task automatic report_field(string field, logic [DATA_BITS-1:0] want,
         logic [DATA_BITS-1:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, next_pc %h status %h",
                        $time, rsp_next_pc, rsp_status);
               errors++;
            end else begin
               want = expected_results.pop_front();
               outstanding--;
               if (rsp_next_pc !== want.next_pc)
                  report_field("next_pc", want.next_pc, rsp_next_pc);
               if (rsp_status !== want.status)
                  report_field("status", want.status, rsp_status);
               if (rsp_reg_write !== want.reg_write)
                  report_field("reg_write", want.reg_write, rsp_reg_write);
               if (rsp_reg_index !== want.reg_index)
                  report_field("reg_index", want.reg_index, rsp_reg_index);
               if (rsp_reg_value !== want.reg_value)
                  report_field("reg_value", want.reg_value, rsp_reg_value);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: run did not finish in time, %0d results outstanding", $time, outstanding);
      $display("** mips_subset_execute_unit: FAILED **");
      $finish;
   end

   initial begin
      vector_row            rows [$];
      logic [PE_BITS-1:0]   pe_low, pe_mid;
      foreach (reg_file_m[i]) reg_file_m[i] = '0;
      foreach (data_mem_m[i]) data_mem_m[i] = '0;
      program_end_m = '0;
      pe_low = $urandom_range(1, 64);
      pe_mid = $urandom_range(200, 4000);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle = 34;
      recv_idle = 80;
      set_program_end('0);

      rows.push_back(row(encode(1'b0, OP_ADD, 5'd1, 5'd2, {5'd3, 11'd0}), 26'd0, 1'b1,
                         {26'd1, ST_OK, 1'b1, 5'd1, 32'd0}));
      rows.push_back(row(encode(1'b0, OP_ADDI, 5'd1, 5'd0, 16'hFFFF), 26'd5, 1'b1,
                         {26'd6, ST_OK, 1'b1, 5'd1, 32'd65535}));
      rows.push_back(row(encode(1'b0, OP_ADDI, 5'd2, 5'd1, 16'hFFFF), 26'd6, 1'b0, NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_SUB, 5'd3, 5'd0, {5'd1, 11'd0}), 26'd7, 1'b0,
                         NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_MUL, 5'd4, 5'd3, {5'd3, 11'd0}), 26'd8, 1'b0,
                         NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_MUL, 5'd5, 5'd2, {5'd2, 11'h7FF}), 26'd9, 1'b0,
                         NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_SLT, 5'd6, 5'd3, {5'd1, 11'd0}), 26'd10, 1'b0,
                         NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_SLT, 5'd7, 5'd1, {5'd3, 11'd0}), 26'd11, 1'b0,
                         NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_BEQ, 5'd0, 5'd8, 16'hFFFF), 26'd100, 1'b1,
                         {26'hFFFF, ST_OK, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row(encode(1'b0, OP_BNE, 5'd1, 5'd2, 16'h1234), 26'd7, 1'b0, NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_BNE, 5'd0, 5'd8, 16'd7), 26'h3FF_FFFF, 1'b1,
                         {26'd0, ST_OK, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row({1'b0, OP_J, 26'h3FF_FFFF}, 26'd3, 1'b1,
                         {26'h3FF_FFFF, ST_OK, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row({1'b1, OP_J, 26'h0}, 26'd9, 1'b1, {26'd0, ST_OK, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row({1'b0, OP_NONE, 26'h2AA_AAAA}, 26'h2AA_AAAA, 1'b1,
                         {26'h2AA_AAAA, ST_BAD_OP, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row(32'hFFFF_FFFF, 26'h155_5555, 1'b1,
                         {26'h155_5555, ST_BAD_OP, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row({1'b0, OP_ADDI + 5'd1, 26'h155_5555}, 26'd12, 1'b1,
                         {26'd12, ST_BAD_OP, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row(encode(1'b0, OP_SW, 5'd1, 5'd0, 16'd0), 26'd20, 1'b1,
                         {26'd20, ST_FAULT, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row(encode(1'b0, OP_LW, 5'd9, 5'd3, 16'd0), 26'd21, 1'b1,
                         {26'd21, ST_FAULT, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row(encode(1'b0, OP_SW, 5'd1, 5'd0, 16'h3FFD), 26'd22, 1'b1,
                         {26'd22, ST_FAULT, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row(encode(1'b0, OP_LW, 5'd9, 5'd0, 16'h4000), 26'd23, 1'b1,
                         {26'd23, ST_FAULT, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row(encode(1'b0, OP_SW, 5'd1, 5'd0, 16'd40), 26'd24, 1'b1,
                         {26'd25, ST_OK, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row(encode(1'b0, OP_SW, 5'd3, 5'd0, 16'd42), 26'd25, 1'b0, NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_LW, 5'd9, 5'd0, 16'd40), 26'd26, 1'b0, NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_LW, 5'd10, 5'd0, 16'd43), 26'd27, 1'b0, NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_SW, 5'd1, 5'd0, 16'h3FFC), 26'd28, 1'b1,
                         {26'd29, ST_OK, 1'b0, 5'd0, 32'd0}));
      rows.push_back(row(encode(1'b0, OP_LW, 5'd11, 5'd0, 16'h3FFC), 26'd29, 1'b0, NO_RESULT));
      rows.push_back(row(encode(1'b0, OP_ADDI, 5'd0, 5'd0, 16'd1), 26'd30, 1'b1,
                         {26'd31, ST_OK, 1'b1, 5'd0, 32'd1}));

      foreach (rows[i]) issue(rows[i].word, rows[i].pc, rows[i].typed, rows[i].res);

      run_segment(34, 80, pe_low, 220);
      run_segment(80, 34, PE_BITS'(MEM_WORDS), 40);
      run_segment(80, 34, pe_mid, 180);
      run_segment(0, 0, '0, 210);

      drain();
      repeat (16) @(posedge clock);
      $display("ran %0d instructions (%0d directed): %0d memory accesses done, %0d faults, %0d unknown opcodes",
               n_items, rows.size(), n_mem_ok, n_faults, n_bad_ops);
      $display("program_end 0, %0d, %0d, %0d; idle on either side and none", pe_low,
               MEM_WORDS, pe_mid);
      if (errors == 0) begin
         $display("** mips_subset_execute_unit: PASSED **");
      end else begin
         $display("%0d mismatches", errors);
         $display("** mips_subset_execute_unit: FAILED **");
      end
      $finish;
   end

endmodule
